[hdl/srde_pkg.sv]
package srde_pkg;

	localparam int DEF_MAX_RADIX   = 16;
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_DIGIT_DEPTH = 32;

	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 8;
	localparam int RADIX_W     = 5;
	localparam int ALPHA_SLOTS = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 5;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	// register slots, taken from paddr[4:3]
	localparam logic [1:0] REG_RADIX    = 2'd0;
	localparam logic [1:0] REG_CHARS_LO = 2'd1;
	localparam logic [1:0] REG_CHARS_HI = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_FETCH,
		ST_EMIT,
		ST_ERR
	} srde_state_t;

	// character for one digit value, byte k of the alphabet words
	function automatic logic [CHAR_W-1:0] alpha_char(
		input logic [CFG_DATA_W-1:0] chars_lo,
		input logic [CFG_DATA_W-1:0] chars_hi,
		input logic [DIGIT_W-1:0]    digit
	);
		logic [CFG_DATA_W-1:0] word;
		begin
			word = digit[DIGIT_W-1] ? chars_hi : chars_lo;
			return word[digit[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
		end
	endfunction

endpackage

[hdl/srde_alpha_check.sv]
module srde_alpha_check
	import srde_pkg::*;
#(
	parameter int MAX_RADIX = DEF_MAX_RADIX
) (
	input  logic [RADIX_W-1:0]    radix_length,
	input  logic [CFG_DATA_W-1:0] chars_lo,
	input  logic [CFG_DATA_W-1:0] chars_hi,
	output logic                  alpha_ok
);

	always_comb begin
		alpha_ok = 1'b1;
		if (radix_length < RADIX_W'(2) || 32'(radix_length) > MAX_RADIX ||
				radix_length > RADIX_W'(ALPHA_SLOTS)) begin
			alpha_ok = 1'b0;
		end
		// forbidden characters and pairwise repeats among the characters in use
		for (int i = 0; i < ALPHA_SLOTS; i++) begin
			if (RADIX_W'(i) < radix_length) begin
				if (alpha_char(chars_lo, chars_hi, DIGIT_W'(i)) == CHAR_NUL ||
						alpha_char(chars_lo, chars_hi, DIGIT_W'(i)) == CHAR_PLUS ||
						alpha_char(chars_lo, chars_hi, DIGIT_W'(i)) == CHAR_MINUS) begin
					alpha_ok = 1'b0;
				end
				for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
					if (RADIX_W'(j) < radix_length &&
							alpha_char(chars_lo, chars_hi, DIGIT_W'(j)) ==
							alpha_char(chars_lo, chars_hi, DIGIT_W'(i))) begin
						alpha_ok = 1'b0;
					end
				end
			end
		end
	end

endmodule

[hdl/srde_divider.sv]
module srde_divider
	import srde_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [RADIX_W-1:0]     divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [DIGIT_W-1:0]     remainder
);

	localparam int CNW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] work_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     div_q;
	logic [CNW-1:0]         cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [RADIX_W-1:0]     trial;
	logic                   ge;
	logic [RADIX_W-1:0]     diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, work_q[VALUE_WIDTH-1]};
	assign ge    = trial >= div_q;
	assign diff  = trial - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNW'(1);
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[VALUE_WIDTH-2:0], ge};
			rem_q  <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule

[hdl/signed_radix_digit_emitter_core.sv]
// each digit comes from one run of the serial divider, then each character takes a
// digit store read (ST_FETCH) and then an output load (ST_EMIT); an alphabet error
// goes straight to the error result (ST_ERR), with no digits and no sign
// one request in flight at a time; the next is taken once its last character is loaded
// arst_n low clears the sequencer, counters, output valid and the config registers
module signed_radix_digit_emitter_core
	import srde_pkg::*;
#(
	parameter int MAX_RADIX   = DEF_MAX_RADIX,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int DIGIT_DEPTH = DEF_DIGIT_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// apb-style config port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [CFG_DATA_W-1:0]  pwdata,
	output logic [CFG_DATA_W-1:0]  prdata,
	output logic                   pready,
	// request channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] number,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CHAR_W-1:0]      text_char,
	output logic                   last_char,
	output logic                   bad_radix
);

	localparam int AW = $clog2(DIGIT_DEPTH);
	localparam int CW = $clog2(DIGIT_DEPTH + 1);

	// config registers
	logic [RADIX_W-1:0]    radix_q;
	logic [CFG_DATA_W-1:0] chars_lo_q;
	logic [CFG_DATA_W-1:0] chars_hi_q;
	logic                  cfg_wr;

	// sequencer
	srde_state_t state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         count_dec;
	logic                  neg_q, neg_d;
	logic                  in_accept;
	logic                  alpha_ok;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic                  slot_free;

	// divider hookup
	logic                   div_start;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic [DIGIT_W-1:0]     div_rem;

	// digit store
	logic [DIGIT_W-1:0] digit_mem [DIGIT_DEPTH];
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [DIGIT_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [DIGIT_W-1:0] rd_data_q;

	// output register
	logic              out_valid_q;
	logic              load_out;
	logic [CHAR_W-1:0] out_char_d;
	logic              out_last_d;
	logic              out_bad_d;

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= '0;
			chars_lo_q <= '0;
			chars_hi_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_RADIX:    radix_q    <= pwdata[RADIX_W-1:0];
				REG_CHARS_LO: chars_lo_q <= pwdata;
				REG_CHARS_HI: chars_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_RADIX:    prdata = CFG_DATA_W'(radix_q);
			REG_CHARS_LO: prdata = chars_lo_q;
			REG_CHARS_HI: prdata = chars_hi_q;
			default:      prdata = '0;
		endcase
	end

	// ---------------- alphabet validation ----------------
	srde_alpha_check #(
		.MAX_RADIX(MAX_RADIX)
	) u_alpha_check (
		.radix_length(radix_q),
		.chars_lo    (chars_lo_q),
		.chars_hi    (chars_hi_q),
		.alpha_ok    (alpha_ok)
	);

	// ---------------- serial divider, reused for every digit ----------------
	srde_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (radix_q),
		.done     (div_done),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	// unsigned magnitude, so the most negative value stays exact
	assign in_mag       = number[VALUE_WIDTH-1] ? (~number + VALUE_WIDTH'(1)) : number;
	// first division works on the request, later ones on the last quotient
	assign div_dividend = (state_q == ST_IDLE) ? in_mag : div_quot;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid & ~in_stall;
	assign slot_free = ~out_valid_q | ~out_stall;
	assign count_dec = count_q - CW'(1);

	// ---------------- sequencer state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			neg_q   <= neg_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		neg_d      = neg_q;
		div_start  = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = count_q[AW-1:0];
		wr_data    = div_rem;
		rd_en      = 1'b0;
		rd_addr    = count_dec[AW-1:0];
		load_out   = 1'b0;
		out_char_d = CHAR_NUL;
		out_last_d = 1'b0;
		out_bad_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					neg_d   = number[VALUE_WIDTH-1];
					count_d = '0;
					if (!alpha_ok) begin
						// no sign on a rejected alphabet
						state_d = ST_ERR;
					end else if (in_mag == '0) begin
						// zero is a single digit of value zero
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = '0;
						count_d = CW'(1);
						state_d = ST_SIGN;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					wr_en   = 1'b1;
					count_d = count_q + CW'(1);
					// stop on a zero quotient or a full store
					if (div_quot == '0 || count_q == CW'(DIGIT_DEPTH - 1)) begin
						state_d = ST_SIGN;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			ST_SIGN: begin
				if (!neg_q) begin
					state_d = ST_FETCH;
				end else if (slot_free) begin
					load_out   = 1'b1;
					out_char_d = CHAR_MINUS;
					state_d    = ST_FETCH;
				end
			end
			ST_FETCH: begin
				// most significant digit sits at the top of the store
				rd_en   = 1'b1;
				count_d = count_dec;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_out   = 1'b1;
					out_char_d = alpha_char(chars_lo_q, chars_hi_q, rd_data_q);
					out_last_d = (count_q == '0);
					state_d    = (count_q == '0) ? ST_IDLE : ST_FETCH;
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					load_out   = 1'b1;
					out_last_d = 1'b1;
					out_bad_d  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- digit store ----------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			digit_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= digit_mem[rd_addr];
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			text_char <= out_char_d;
			last_char <= out_last_d;
			bad_radix <= out_bad_d;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- assertions ----------------
	// a held result is never overwritten by the sequencer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("output register loaded while a result is held");

	// an error result is a lone, final, empty character
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_radix) |-> (last_char && text_char == CHAR_NUL))
		else $error("malformed error result");

	// digit count stays within the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DIGIT_DEPTH))
		else $error("digit count past store depth");

	// divider results only arrive while the sequencer waits for them
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside the divide phase");

	// a new request is only taken with nothing left to send
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> (count_q == '0))
		else $error("request taken with digits still stored");

endmodule

[tb/signed_radix_digit_emitter_core_test.sv]
`timescale 1ns / 1ps

module signed_radix_digit_emitter_core_test;
	import srde_pkg::*;

	// one emitted character as the checker sees it
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} glyph_t;

	// ways to spoil an otherwise good alphabet
	typedef enum int {
		FAULT_SHORT,
		FAULT_WIDE,
		FAULT_PLUS,
		FAULT_MINUS,
		FAULT_NUL,
		FAULT_REPEAT
	} alphabet_fault_t;

	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int PHASE_ITEMS    = 21;
	localparam int NOISE_ITEMS    = 6;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 40;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CFG_ADDR_W-1:0]  paddr;
	logic [CFG_DATA_W-1:0]  pwdata;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_stall;
	logic [31:0]            number;
	logic                   out_valid;
	logic                   out_stall;
	logic [CHAR_W-1:0]      text_char;
	logic                   last_char;
	logic                   bad_radix;

	// predictor's copy of the alphabet registers
	logic [RADIX_W-1:0]     cfg_radix;
	logic [CFG_DATA_W-1:0]  cfg_chars_lo;
	logic [CFG_DATA_W-1:0]  cfg_chars_hi;

	// characters still owed by the block, oldest first
	glyph_t                 expected_text[$];

	int                     fail_count;
	int                     cycle_count;
	int                     numbers_sent;
	int                     chars_checked;
	int                     rejections_seen;
	int                     alphabet_loads;
	logic [31:0]            radix_seen;
	bit                     calm;
	int                     hold_request;

	signed_radix_digit_emitter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.number    (number),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.last_char (last_char),
		.bad_radix (bad_radix)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run watchdog, generous against the slowest legal run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// character for digit value v, byte v of the 128-bit alphabet
	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [3:0] v);
		logic [127:0] glyphs;
		glyphs = {cfg_chars_hi, cfg_chars_lo};
		return glyphs[v*CHAR_W +: CHAR_W];
	endfunction

	// radix in range, no forbidden byte and no repeat among the used slots
	function automatic bit alphabet_valid();
		int i;
		int j;
		logic [CHAR_W-1:0] c;
		if (cfg_radix < 2 || cfg_radix > DEF_MAX_RADIX)
			return 1'b0;
		for (i = 0; i < cfg_radix; i++) begin
			c = digit_glyph(i[3:0]);
			if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS)
				return 1'b0;
			for (j = i + 1; j < cfg_radix; j++)
				if (digit_glyph(j[3:0]) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// queue up the text the block should write for one number
	task automatic predict_text(input logic [31:0] value);
		logic [31:0] mag;
		logic [31:0] base;
		logic [3:0]  digits[32];
		int          n;
		int          k;
		begin
			if (!alphabet_valid()) begin
				expected_text.push_back({CHAR_NUL, 1'b1, 1'b1});
			end else begin
				radix_seen[cfg_radix] = 1'b1;
				base = 32'(cfg_radix);
				// unsigned magnitude, so the most negative value is fine
				mag = value[31] ? -value : value;
				n = 0;
				if (mag == 0) begin
					digits[0] = 4'd0;
					n = 1;
				end
				while (mag != 0) begin
					digits[n] = 4'(mag % base);
					mag = mag / base;
					n++;
				end
				if (value[31])
					expected_text.push_back({CHAR_MINUS, 1'b0, 1'b0});
				for (k = n - 1; k >= 0; k--)
					expected_text.push_back({digit_glyph(digits[k]), k == 0, 1'b0});
			end
		end
	endtask

	// ------------------------------------------------------------------
	// result side: random stalls plus an optional long hold-off
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 34);
			end
		end
	end

	// compare each accepted character with the oldest expectation
	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				$error("unexpected result: text_char %h last_char %b bad_radix %b",
					text_char, last_char, bad_radix);
				fail_count++;
			end else begin
				want = expected_text.pop_front();
				chars_checked++;
				if (bad_radix)
					rejections_seen++;
				if (text_char !== want.ch) begin
					$error("text_char: expected %h, got %h", want.ch, text_char);
					fail_count++;
				end
				if (last_char !== want.last) begin
					$error("last_char: expected %b, got %b", want.last, last_char);
					fail_count++;
				end
				if (bad_radix !== want.bad) begin
					$error("bad_radix: expected %b, got %b", want.bad, bad_radix);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// request side and config port
	// ------------------------------------------------------------------

	// offer one number, with a random gap first, and wait for it to be taken
	task automatic send_number(input logic [31:0] value);
		int gap;
		begin
			@(negedge clk);
			gap = 0;
			if (!calm && $urandom_range(0, 99) < 34)
				gap = $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid <= 1'b1;
			number   <= value;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			predict_text(value);
			numbers_sent++;
		end
	endtask

	// stop offering, then wait for every owed character and a short tail
	task automatic settle_block();
		begin
			@(negedge clk);
			in_valid <= 1'b0;
			while (expected_text.size() != 0)
				@(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
		end
	endtask

	task automatic apb_write(input logic [1:0] slot, input logic [CFG_DATA_W-1:0] data);
		begin
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {slot, 3'b000};
			pwdata  <= data;
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			// register takes the value at this edge
			case (slot)
				REG_RADIX:    cfg_radix    = data[RADIX_W-1:0];
				REG_CHARS_LO: cfg_chars_lo = data;
				REG_CHARS_HI: cfg_chars_hi = data;
				default: ;
			endcase
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic apb_read_check(input logic [1:0] slot, input logic [CFG_DATA_W-1:0] want,
			input logic [CFG_DATA_W-1:0] mask);
		logic [CFG_DATA_W-1:0] got;
		begin
			@(negedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {slot, 3'b000};
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			got = prdata;
			if ((got & mask) !== (want & mask)) begin
				$error("prdata slot %0d: expected %h, got %h", slot, want & mask, got & mask);
				fail_count++;
			end
			@(negedge clk);
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// reprogram the alphabet while idle, then read every register back
	task automatic load_alphabet(input logic [CFG_DATA_W-1:0] radix_word,
			input logic [127:0] glyphs);
		begin
			settle_block();
			apb_write(REG_RADIX, radix_word);
			apb_write(REG_CHARS_LO, glyphs[63:0]);
			apb_write(REG_CHARS_HI, glyphs[127:64]);
			apb_read_check(REG_RADIX, {59'd0, cfg_radix}, 64'h1F);
			apb_read_check(REG_CHARS_LO, cfg_chars_lo, '1);
			apb_read_check(REG_CHARS_HI, cfg_chars_hi, '1);
			alphabet_loads++;
		end
	endtask

	// byte k of the result holds character k of the text
	function automatic logic [127:0] text_glyphs(input string s);
		logic [127:0] g;
		int k;
		g = '0;
		for (k = 0; k < s.len() && k < ALPHA_SLOTS; k++)
			g[k*CHAR_W +: CHAR_W] = s[k];
		return g;
	endfunction

	// n distinct usable characters, the unused slots anything at all
	function automatic logic [127:0] random_glyphs(input int n);
		logic [127:0] g;
		logic [255:0] taken;
		logic [7:0]   c;
		int k;
		taken = '0;
		taken[CHAR_NUL]   = 1'b1;
		taken[CHAR_PLUS]  = 1'b1;
		taken[CHAR_MINUS] = 1'b1;
		for (k = 0; k < ALPHA_SLOTS; k++) begin
			c = 8'($urandom_range(0, 255));
			if (k < n) begin
				while (taken[c])
					c = 8'($urandom_range(0, 255));
				taken[c] = 1'b1;
			end
			g[k*CHAR_W +: CHAR_W] = c;
		end
		return g;
	endfunction

	// radix register value with junk above the used bits
	function automatic logic [CFG_DATA_W-1:0] radix_word(input int n);
		logic [CFG_DATA_W-1:0] w;
		w = {$urandom, $urandom};
		w[RADIX_W-1:0] = RADIX_W'(n);
		return w;
	endfunction

	// mix of full-range values, small ones, values near the ends and odd widths
	function automatic logic [31:0] pick_number();
		logic [31:0] v;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			v = $urandom;
		end else if (kind < 6) begin
			v = $urandom_range(0, 200) - 100;
		end else if (kind == 6) begin
			v = 32'h7FFF_FFFF - $urandom_range(0, 3);
		end else if (kind == 7) begin
			v = 32'h8000_0000 + $urandom_range(0, 3);
		end else begin
			v = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// registers come up zero, so radix 0 must be rejected
	task automatic test_reset_state();
		begin
			apb_read_check(REG_RADIX, '0, 64'h1F);
			apb_read_check(REG_CHARS_LO, '0, '1);
			apb_read_check(REG_CHARS_HI, '0, '1);
			send_number(32'd0);
			send_number(-32'sd5);
		end
	endtask

	// decimal: zero, one digit, carries and both ends of the range
	task automatic test_decimal_extremes();
		begin
			load_alphabet(64'd10, text_glyphs("0123456789"));
			send_number(32'd0);
			send_number(32'd1);
			send_number(32'hFFFF_FFFF);
			send_number(32'd9);
			send_number(32'd10);
			send_number(-32'sd10);
			send_number(32'h7FFF_FFFF);
			send_number(32'h8000_0000);
		end
	endtask

	// widest alphabet uses the high word; binary gives the longest text
	task automatic test_hex_and_binary();
		begin
			load_alphabet(64'd16, text_glyphs("0123456789abcdef"));
			send_number(32'hFFFF_FFFF);
			send_number(32'hDEAD_BEEF);
			send_number(32'h7FFF_FFFF);
			load_alphabet(64'd2, text_glyphs("01"));
			send_number(32'h8000_0000);
			send_number(32'h7FFF_FFFF);
			send_number(32'd0);
		end
	endtask

	// every reason to reject an alphabet, then one that only looks bad
	task automatic test_alphabet_rules();
		begin
			// too short
			load_alphabet(64'd1, text_glyphs("0123456789"));
			send_number(32'd7);
			// radix beyond the alphabet slots
			load_alphabet(64'd17, text_glyphs("0123456789abcdef"));
			send_number(32'd7);
			load_alphabet(64'd31, text_glyphs("0123456789abcdef"));
			send_number(-32'sd7);
			// forbidden characters inside the used range
			load_alphabet(64'd4, text_glyphs("01+3"));
			send_number(32'd7);
			load_alphabet(64'd4, text_glyphs("0-23"));
			send_number(-32'sd7);
			load_alphabet(64'd3, text_glyphs("01"));
			send_number(32'd7);
			// repeated character
			load_alphabet(64'd5, text_glyphs("abcda"));
			send_number(32'd7);
			// forbidden and repeated bytes past the radix do not count
			load_alphabet(64'd3, text_glyphs("xyz+-x"));
			send_number(32'd5);
			send_number(-32'sd7);
		end
	endtask

	// random alphabets and numbers, with a few spoiled alphabets mixed in
	task automatic test_random_alphabets();
		int p;
		int i;
		int n;
		int pos;
		logic [127:0] glyphs;
		alphabet_fault_t fault;
		begin
			for (p = 0; p < 11; p++) begin
				if (p == 3 || p == 7) begin
					// spoiled alphabet, every number gets the error result
					n = $urandom_range(2, DEF_MAX_RADIX);
					glyphs = random_glyphs(n);
					fault = alphabet_fault_t'($urandom_range(FAULT_SHORT, FAULT_REPEAT));
					pos = $urandom_range(0, n - 1);
					case (fault)
						FAULT_SHORT: n = $urandom_range(0, 1);
						FAULT_WIDE:  n = $urandom_range(DEF_MAX_RADIX + 1, 31);
						FAULT_PLUS:  glyphs[pos*CHAR_W +: CHAR_W] = CHAR_PLUS;
						FAULT_MINUS: glyphs[pos*CHAR_W +: CHAR_W] = CHAR_MINUS;
						FAULT_NUL:   glyphs[pos*CHAR_W +: CHAR_W] = CHAR_NUL;
						default: begin
							pos = $urandom_range(1, n - 1);
							glyphs[pos*CHAR_W +: CHAR_W] =
								glyphs[$urandom_range(0, pos - 1)*CHAR_W +: CHAR_W];
						end
					endcase
					load_alphabet(radix_word(n), glyphs);
					for (i = 0; i < NOISE_ITEMS; i++)
						send_number(pick_number());
				end else begin
					// smallest and largest radix first, then anything
					if (p == 0)
						n = 2;
					else if (p == 1)
						n = DEF_MAX_RADIX;
					else
						n = $urandom_range(2, DEF_MAX_RADIX);
					load_alphabet(radix_word(n), random_glyphs(n));
					// one phase runs with no idling on either side
					calm = (p == 4);
					for (i = 0; i < PHASE_ITEMS; i++)
						send_number(pick_number());
				end
			end
			settle_block();
			calm = 1'b0;
		end
	endtask

	// receiver holds off for a long stretch while numbers keep coming
	task automatic test_backpressure();
		int i;
		begin
			load_alphabet(radix_word(10), random_glyphs(10));
			hold_request = HOLD_OFF_LEN;
			for (i = 0; i < 8; i++)
				send_number(pick_number());
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		fail_count      = 0;
		cycle_count     = 0;
		numbers_sent    = 0;
		chars_checked   = 0;
		rejections_seen = 0;
		alphabet_loads  = 0;
		radix_seen      = '0;
		calm            = 1'b0;
		hold_request    = 0;
		cfg_radix       = '0;
		cfg_chars_lo    = '0;
		cfg_chars_hi    = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_valid        = 1'b0;
		number          = '0;

		// single reset at the start of the run
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_decimal_extremes();
		test_hex_and_binary();
		test_alphabet_rules();
		test_random_alphabets();
		test_backpressure();

		// stop offering and let every owed character drain out
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d numbers written out under %0d alphabet loads, %0d radices in use",
			numbers_sent, alphabet_loads, $countones(radix_seen));
		$display("%0d characters compared, %0d of them alphabet rejections",
			chars_checked, rejections_seen);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
